// ===== rtl/psq_pkg.sv =====
// Pitch scale quantizer: shared package.
// Holds the sequencer state type, the divider and search interface structs,
// and the fixed widths and constants. No dependencies.
package psq_pkg;

   // widths fixed by the data formats
   localparam int VOLTS_W  = 16;
   localparam int FS_W     = 15;
   localparam int GAIN_W   = 16;
   localparam int MOD_W    = 6;
   localparam int COUNT_W  = 5;
   localparam int DEG_W    = 8;
   localparam int NOTE_W   = 7;
   localparam int CODE_W   = 12;
   localparam int PITCH_W  = 15;
   localparam int REM_W    = 14;
   localparam int PROD_W   = 33;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // shared restoring divider
   localparam int DVD_W  = 26;
   localparam int DIV_W  = 15;
   localparam int QUO_W  = 12;
   localparam int STEP_W = 4;

   localparam logic [PITCH_W-1:0]  PITCH_MAX    = 15'd32512;
   localparam logic signed [23:0]  PITCH_CENTER = 24'sd15360;
   localparam logic [CODE_W-1:0]   CODE_MAX     = 12'h7FF;
   localparam logic [NOTE_W-1:0]   NOTE_RESET   = 7'd60;
   localparam logic [15:0]         ROUND_HALF   = 16'd128;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_QUANT_EN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEG_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEG_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEG_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PITCH,
      ST_PASS,
      ST_DIV_WAIT,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] target;
   } srch_req_type;

endpackage

// ===== rtl/psq_div.sv =====
// Pitch scale quantizer: shared restoring divider, one quotient bit per cycle.
// Quotient must fit in QUO_W bits (dividend >> QUO_W below the divisor).
// Depends on psq_pkg.
module psq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  psq_pkg::div_req_type req,
   output psq_pkg::div_rsp_type rsp
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [psq_pkg::STEP_W-1:0]  step_ff;
   logic [psq_pkg::DIV_W-1:0]   part_ff;
   logic [psq_pkg::QUO_W-1:0]   quo_ff;
   logic [psq_pkg::DIV_W-1:0]   divisor_ff;

   logic [psq_pkg::DIV_W:0]     trial;
   logic [psq_pkg::DIV_W:0]     shifted;
   logic                        fits;

   always_comb begin
      shifted = {part_ff, quo_ff[psq_pkg::QUO_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      fits    = !trial[psq_pkg::DIV_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == psq_pkg::STEP_W'(psq_pkg::QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // quotient bits shift in from the bottom as dividend bits leave the top
   always_ff @(posedge clock) begin
      if (req.start) begin
         part_ff    <= psq_pkg::DIV_W'(req.dividend[psq_pkg::DVD_W-1:psq_pkg::QUO_W]);
         quo_ff     <= req.dividend[psq_pkg::QUO_W-1:0];
         divisor_ff <= req.divisor;
      end else if (busy_ff) begin
         part_ff <= fits ? trial[psq_pkg::DIV_W-1:0] : shifted[psq_pkg::DIV_W-1:0];
         quo_ff  <= {quo_ff[psq_pkg::QUO_W-2:0], fits};
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = part_ff;

endmodule

// ===== rtl/psq_search.sv =====
// Pitch scale quantizer: nearest scale degree search, one degree per cycle.
// Shared compare unit; lowest index wins a tie. Depends on psq_pkg.
module psq_search #(
   parameter  int MAX_DEGREES = 16,
   localparam int CNT_W       = $clog2(MAX_DEGREES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psq_pkg::srch_req_type         req,
   input  logic [CNT_W-1:0]              count,
   input  logic [psq_pkg::MOD_W-1:0]     modulus,
   input  logic [psq_pkg::DEG_W-1:0]     degree,
   output logic [CNT_W-1:0]              index,
   output logic                          done,
   output logic [psq_pkg::REM_W-1:0]     best
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic [psq_pkg::REM_W-1:0]   target_ff;
   logic [psq_pkg::REM_W-1:0]   best_ff;
   logic [psq_pkg::REM_W-1:0]   min_err_ff;

   logic [psq_pkg::DEG_W-1:0]   deg_clip;
   logic [psq_pkg::REM_W-1:0]   deg_q;
   logic [psq_pkg::REM_W-1:0]   err;
   logic                        take;
   logic                        last;

   always_comb begin
      // degrees at or past the modulus fold to the top semitone
      if (degree >= {modulus, 2'b00}) begin
         deg_clip = {modulus - 1'b1, 2'b00};
      end else begin
         deg_clip = degree;
      end
      deg_q = {deg_clip, 6'b000000};
      err   = (target_ff > deg_q) ? (target_ff - deg_q) : (deg_q - target_ff);
      take  = (idx_ff == '0) || (err < min_err_ff);
      last  = ((idx_ff + CNT_W'(1)) == count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         target_ff <= req.target;
      end
      if (busy_ff && take) begin
         best_ff    <= deg_q;
         min_err_ff <= err;
      end
   end

   assign index = idx_ff;
   assign done  = done_ff;
   assign best  = best_ff;

endmodule

// ===== rtl/pitch_scale_quantizer_top.sv =====
// Pitch scale quantizer: top level with configuration registers, sequencer,
// output register and per-channel last note. Uses psq_pkg, psq_div, psq_search.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_channel/volts | in, stall driven here
//   rsp     | rsp_valid, rsp_stall, rsp_is_note/...   | out, stall driven by sink
//   csr     | csr_write_enable, csr_index, csr_data   | in, write only
//
// Pass-through item: PASS, DIV_WAIT over 12 divider steps, FINISH; straight to FINISH when full scale is 0.
// Quantized item: MUL, PITCH, DIV_WAIT, then SEARCH over N = min(degree_count, MAX_DEGREES) search steps, FINISH.
// FINISH waits for a free output register to load the result; req_stall drops in the cycle after the load.
// Reset is synchronous; configuration takes its reset values, last notes go invalid.
// req_stall is high while an item is in work; a result waiting in the output
// register does not block the next transfer on req.
module pitch_scale_quantizer_top #(
   parameter int MAX_DEGREES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_channel,
   input  logic signed [psq_pkg::VOLTS_W-1:0]  req_volts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_note,
   output logic [psq_pkg::NOTE_W-1:0]          rsp_note,
   output logic                                rsp_note_write,
   output logic signed [psq_pkg::CODE_W-1:0]   rsp_cv_code,
   input  logic                                csr_write_enable,
   input  logic [psq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psq_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CNT_W  = $clog2(MAX_DEGREES + 1);
   localparam int DIDX_W = (MAX_DEGREES > 1) ? $clog2(MAX_DEGREES) : 1;

   // configuration
   logic                               quant_en_ff;
   logic [psq_pkg::MOD_W-1:0]          modulus_ff;
   logic [psq_pkg::COUNT_W-1:0]        deg_count_ff;
   logic [psq_pkg::GAIN_W-1:0]         gain_ff;
   logic [psq_pkg::DEG_W-1:0]          deg_ff [MAX_DEGREES];
   logic [psq_pkg::FS_W-1:0]           full_scale_ff;

   // item in work
   psq_pkg::state_type                 state_ff, state_in;
   logic [1:0]                         ch_ff;
   logic signed [psq_pkg::VOLTS_W-1:0] volts_ff;
   logic                               quant_ff;
   logic signed [psq_pkg::PROD_W-1:0]  prod_ff;
   logic [psq_pkg::PITCH_W-1:0]        pitch_ff;
   logic [psq_pkg::REM_W-1:0]          rem_ff;

   // last note per output
   logic [psq_pkg::NOTE_W-1:0]         last_note_ff [4];
   logic [3:0]                         last_valid_ff;

   // output register
   logic                               rsp_valid_ff;
   logic                               is_note_ff, is_note_in;
   logic [psq_pkg::NOTE_W-1:0]         note_ff, note_in;
   logic                               note_write_ff, note_write_in;
   logic [psq_pkg::CODE_W-1:0]         code_ff, code_in;

   psq_pkg::div_req_type               div_req;
   psq_pkg::div_rsp_type               div_rsp;
   psq_pkg::srch_req_type              srch_req;
   logic [CNT_W-1:0]                   srch_idx;
   logic                               srch_done;
   logic [psq_pkg::REM_W-1:0]          srch_best;
   logic [CNT_W-1:0]                   deg_n;
   logic [psq_pkg::DEG_W-1:0]          deg_sel;

   logic                               accept;
   logic                               quant_sel;
   logic                               out_free;
   logic                               out_load;
   logic signed [23:0]                 pitch_s;
   logic [psq_pkg::PITCH_W-1:0]        pitch_c;
   logic [16:0]                        v_mag;
   logic [psq_pkg::FS_W-1:0]           v_clamp;
   logic [psq_pkg::REM_W-1:0]          rem_c;
   logic [15:0]                        rebuilt;
   logic [15:0]                        rebuilt_clamp;
   logic [15:0]                        rounded;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_en_ff   <= 1'b0;
         modulus_ff    <= 6'd12;
         deg_count_ff  <= '0;
         gain_ff       <= 16'd3072;
         full_scale_ff <= 15'd5120;
      end else if (csr_write_enable) begin
         case (csr_index)
            psq_pkg::REG_QUANT_EN:   quant_en_ff   <= csr_data[0];
            psq_pkg::REG_MODULUS:    modulus_ff    <= csr_data[psq_pkg::MOD_W-1:0];
            psq_pkg::REG_DEG_COUNT:  deg_count_ff  <= csr_data[psq_pkg::COUNT_W-1:0];
            psq_pkg::REG_GAIN:       gain_ff       <= csr_data[psq_pkg::GAIN_W-1:0];
            psq_pkg::REG_FULL_SCALE: full_scale_ff <= csr_data[psq_pkg::FS_W-1:0];
            default: ;
         endcase
      end
   end

   // degree bytes: low word holds degrees 0..7, high word 8..15
   for (genvar k = 0; k < MAX_DEGREES; k++) begin : g_deg
      localparam logic [psq_pkg::CSR_IDX_W-1:0] SRC =
         (k < 8) ? psq_pkg::REG_DEG_LOW : psq_pkg::REG_DEG_HIGH;
      localparam int LSB = (k % 8) * psq_pkg::DEG_W;
      always_ff @(posedge clock) begin
         if (reset) begin
            deg_ff[k] <= '0;
         end else if (csr_write_enable && (csr_index == SRC)) begin
            deg_ff[k] <= csr_data[LSB +: psq_pkg::DEG_W];
         end
      end
   end

   // ---------------- sequencer ----------------
   assign accept    = req_valid && !req_stall;
   assign quant_sel = req_channel[1] && quant_en_ff && (deg_count_ff != '0) &&
                      (modulus_ff != '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psq_pkg::ST_IDLE: begin
            if (accept) begin
               if (quant_sel) begin
                  state_in = psq_pkg::ST_MUL;
               end else if (full_scale_ff == '0) begin
                  state_in = psq_pkg::ST_FINISH;
               end else begin
                  state_in = psq_pkg::ST_PASS;
               end
            end
         end
         psq_pkg::ST_MUL:   state_in = psq_pkg::ST_PITCH;
         psq_pkg::ST_PITCH: state_in = psq_pkg::ST_DIV_WAIT;
         psq_pkg::ST_PASS:  state_in = psq_pkg::ST_DIV_WAIT;
         psq_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = quant_ff ? psq_pkg::ST_SEARCH : psq_pkg::ST_FINISH;
            end
         end
         psq_pkg::ST_SEARCH: begin
            if (srch_done) begin
               state_in = psq_pkg::ST_FINISH;
            end
         end
         psq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = psq_pkg::ST_IDLE;
            end
         end
         default: state_in = psq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath feeding the shared units
   always_comb begin
      // floor(prod / 1024): arithmetic shift of the signed product
      pitch_s = 24'($signed(prod_ff[psq_pkg::PROD_W-1:10])) + psq_pkg::PITCH_CENTER;
      if (pitch_s < 0) begin
         pitch_c = '0;
      end else if (pitch_s > $signed({9'd0, psq_pkg::PITCH_MAX})) begin
         pitch_c = psq_pkg::PITCH_MAX;
      end else begin
         pitch_c = pitch_s[psq_pkg::PITCH_W-1:0];
      end

      v_mag = volts_ff[psq_pkg::VOLTS_W-1] ?
              (17'd0 - {volts_ff[psq_pkg::VOLTS_W-1], volts_ff}) : {1'b0, volts_ff};
      v_clamp = (v_mag > {2'b00, full_scale_ff}) ? full_scale_ff : v_mag[psq_pkg::FS_W-1:0];

      rem_c = {div_rsp.remainder[psq_pkg::MOD_W-1:0], pitch_ff[7:0]};
   end

   // sequencer outputs
   always_comb begin
      req_stall       = (state_ff != psq_pkg::ST_IDLE);
      div_req.start   = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      srch_req.start  = 1'b0;
      srch_req.target = rem_c;
      out_load        = 1'b0;
      case (state_ff)
         psq_pkg::ST_PITCH: begin
            // octave = floor(pitch/256) / modulus
            div_req.start    = 1'b1;
            div_req.dividend = psq_pkg::DVD_W'(pitch_c[psq_pkg::PITCH_W-1:8]);
            div_req.divisor  = psq_pkg::DIV_W'(modulus_ff);
         end
         psq_pkg::ST_PASS: begin
            div_req.start    = 1'b1;
            div_req.dividend = {v_clamp, 11'd0};
            div_req.divisor  = full_scale_ff;
         end
         psq_pkg::ST_DIV_WAIT: begin
            srch_req.start = div_rsp.done && quant_ff;
         end
         psq_pkg::ST_FINISH: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   // ---------------- item registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff    <= req_channel;
         volts_ff <= req_volts;
         quant_ff <= quant_sel;
      end
      if (state_ff == psq_pkg::ST_MUL) begin
         prod_ff <= volts_ff * $signed({1'b0, gain_ff});
      end
      if (state_ff == psq_pkg::ST_PITCH) begin
         pitch_ff <= pitch_c;
      end
      if (srch_req.start) begin
         rem_ff <= rem_c;
      end
   end

   psq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign deg_n   = (deg_count_ff > psq_pkg::COUNT_W'(MAX_DEGREES)) ?
                    CNT_W'(MAX_DEGREES) : CNT_W'(deg_count_ff);
   assign deg_sel = deg_ff[srch_idx[DIDX_W-1:0]];

   psq_search #(
      .MAX_DEGREES (MAX_DEGREES)
   ) u_search (
      .clock   (clock),
      .reset   (reset),
      .req     (srch_req),
      .count   (deg_n),
      .modulus (modulus_ff),
      .degree  (deg_sel),
      .index   (srch_idx),
      .done    (srch_done),
      .best    (srch_best)
   );

   // ---------------- result ----------------
   always_comb begin
      // octave * m * 256 equals pitch minus remainder
      rebuilt       = {1'b0, pitch_ff} - {2'b00, rem_ff} + {2'b00, srch_best};
      rebuilt_clamp = (rebuilt > {1'b0, psq_pkg::PITCH_MAX}) ? {1'b0, psq_pkg::PITCH_MAX}
                                                            : rebuilt;
      rounded       = rebuilt_clamp + psq_pkg::ROUND_HALF;

      is_note_in    = quant_ff;
      note_in       = '0;
      note_write_in = 1'b0;
      code_in       = '0;
      if (quant_ff) begin
         note_in       = rounded[14:8];
         note_write_in = !last_valid_ff[ch_ff] || (note_in != last_note_ff[ch_ff]);
      end else if (full_scale_ff != '0) begin
         if (volts_ff[psq_pkg::VOLTS_W-1]) begin
            code_in = '0 - div_rsp.quotient;
         end else if (div_rsp.quotient[psq_pkg::QUO_W-1]) begin
            code_in = psq_pkg::CODE_MAX;
         end else begin
            code_in = div_rsp.quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         is_note_ff    <= is_note_in;
         note_ff       <= note_in;
         note_write_ff <= note_write_in;
         code_ff       <= code_in;
      end
   end

   // any register write drops the last notes
   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            last_note_ff[i] <= psq_pkg::NOTE_RESET;
         end
      end else if (csr_write_enable && (csr_index <= psq_pkg::REG_FULL_SCALE)) begin
         last_valid_ff <= '0;
      end else if (out_load && quant_ff && note_write_in) begin
         last_valid_ff[ch_ff] <= 1'b1;
         last_note_ff[ch_ff]  <= note_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_note    = is_note_ff;
   assign rsp_note       = note_ff;
   assign rsp_note_write = note_write_ff;
   assign rsp_cv_code    = code_ff;

endmodule
